// ===== sv/ppeq_pkg.sv =====
// ----------------------------------------------------------------------------
// ppeq_pkg
// Shared constants, codes, types and helpers of the per-process event queues.
// ----------------------------------------------------------------------------
package ppeq_pkg;

    // Sizing
    localparam int SLOTS       = 32;
    localparam int QUEUE_DEPTH = 32;
    localparam int EVENT_WIDTH = 64;

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W  = (SLOTS * QUEUE_DEPTH > 1) ? $clog2(SLOTS * QUEUE_DEPTH) : 1;
    localparam int STORE_DEPTH = SLOTS * QUEUE_DEPTH;

    // Port field widths
    localparam int CMD_W     = 2;
    localparam int PID_W     = 16;
    localparam int INDEX_W   = 5;
    localparam int DATA_W    = 64;
    localparam int STATUS_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BIND    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Bind write into the owner directory
    typedef struct packed {
        logic               en;
        slot_t              slot;
        logic [PID_W-1:0]   owner;
    } bind_req_t;

    // Owner lookup result
    typedef struct packed {
        logic   hit;
        slot_t  slot;
    } slot_match_t;

    // Step a ring pointer, wrapping at the queue depth
    function automatic ptr_t ptr_advance(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + ptr_t'(1);
        return r;
    endfunction

    // Event store address of one ring entry
    function automatic addr_t store_addr(input slot_t s, input ptr_t p);
        addr_t a;
        a = addr_t'(s) * addr_t'(QUEUE_DEPTH) + addr_t'(p);
        return a;
    endfunction

endpackage

// ===== sv/ppeq_event_ram.sv =====
// ----------------------------------------------------------------------------
// ppeq_event_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppeq_event_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered from the address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/ppeq_slot_dir.sv =====
// ----------------------------------------------------------------------------
// ppeq_slot_dir
// Owner directory: bound flags and owner ids of all slots, a registered
// compare vector against the looked-up process id, and a lowest-slot-first
// priority encoder on that vector.
// ----------------------------------------------------------------------------
module ppeq_slot_dir (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        lookup_en,
    input  logic [ppeq_pkg::PID_W-1:0]  lookup_pid,
    input  ppeq_pkg::bind_req_t         bind_req,
    output ppeq_pkg::slot_match_t       match
);
    import ppeq_pkg::*;

    logic             bound_reg [SLOTS];
    logic [PID_W-1:0] owner_reg [SLOTS];
    logic [SLOTS-1:0] hit_vec_reg;
    logic [SLOTS-1:0] hit_vec_next;

    // Compare every bound slot against the incoming id
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_vec_next[i] = bound_reg[i] && (owner_reg[i] == lookup_pid);
        end
    end

    // Capture the compare vector when a command is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_vec_reg <= '0;
        end
        else if (lookup_en)
        begin
            hit_vec_reg <= hit_vec_next;
        end
    end

    // Bind: set owner and mark the slot bound
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                bound_reg[i] <= 1'b0;
                owner_reg[i] <= '0;
            end
        end
        else if (bind_req.en)
        begin
            bound_reg[bind_req.slot] <= 1'b1;
            owner_reg[bind_req.slot] <= bind_req.owner;
        end
    end

    // Pick the lowest-numbered matching slot
    always_comb
    begin
        match.hit  = 1'b0;
        match.slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                match.hit  = 1'b1;
                match.slot = slot_t'(i);
            end
        end
    end

endmodule

// ===== sv/per_process_event_queues_unit.sv =====
// ----------------------------------------------------------------------------
// per_process_event_queues_unit
// Event rings, one per slot, in a shared event memory; bind, enqueue, poll.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command, process_id, slot_index
//   and event_data. Each command gives exactly one result on the output
//   channel (out_valid/out_ready): status, event_valid, lost_report, event_out.
//   Commands run one at a time through a small sequencer:
//     idle  transfer in, compare process_id with all slot owners
//     look  pick the slot, update ring pointers, write the event memory
//     out   for a poll that dequeues, or when the output is not free
//   A result goes into the output register from the look step, or from the
//   out step once event memory read data returns; a new command is taken in
//   the cycle the result appears. The registered owner compare and the
//   registered read port of the event memory set these steps.
//   Reset clears all slot bindings, ring pointers and lost flags at once;
//   the event memory is not cleared, since a poll only reads entries
//   written since the last bind of its slot.
//   When the receiver stalls, the finished result holds in the output
//   register; the next command is still taken and waits at its last step
//   until the output register frees up.
// ----------------------------------------------------------------------------
module per_process_event_queues_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ppeq_pkg::CMD_W-1:0]     command,
    input  logic [ppeq_pkg::PID_W-1:0]     process_id,
    input  logic [ppeq_pkg::INDEX_W-1:0]   slot_index,
    input  logic [ppeq_pkg::DATA_W-1:0]    event_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ppeq_pkg::STATUS_W-1:0]  status,
    output logic                           event_valid,
    output logic                           lost_report,
    output logic [ppeq_pkg::DATA_W-1:0]    event_out
);
    import ppeq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    // Captured command
    logic [CMD_W-1:0]       cmd_reg;
    logic [PID_W-1:0]       pid_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic [EVENT_WIDTH-1:0] data_reg;

    // Per-slot ring state
    ptr_t wr_ptr_reg [SLOTS];
    ptr_t rd_ptr_reg [SLOTS];
    logic lost_reg   [SLOTS];

    // Pending result while waiting for memory data or a free output
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                pend_valid_reg,  pend_valid_next;
    logic                pend_lost_reg,   pend_lost_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic                event_valid_reg;
    logic                lost_report_reg;
    logic [DATA_W-1:0]   event_out_reg;

    logic                in_xfer;
    logic                out_free;
    slot_match_t         match;
    bind_req_t           bind_req;
    slot_t               sel;
    slot_t               bind_slot;
    logic                bind_ok;

    // Ring updates decided in the lookup step
    logic                wp_step, rp_step, lost_set, lost_clr, ring_clear;

    // Result of the lookup step
    logic [STATUS_W-1:0] res_status;
    logic                res_valid, res_lost;
    logic                load_direct, load_pend;

    // Event memory ports
    logic                ram_we, ram_re;
    addr_t               ram_waddr, ram_raddr;
    logic [EVENT_WIDTH-1:0] ram_rdata;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign sel      = match.slot;
    assign bind_slot = slot_t'(index_reg);
    assign bind_ok   = (int'(index_reg) < SLOTS);

    ppeq_slot_dir u_dir (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_en  (in_xfer),
        .lookup_pid (process_id),
        .bind_req   (bind_req),
        .match      (match)
    );

    ppeq_event_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (EVENT_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (data_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Hold the command fields
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg   <= command;
            pid_reg   <= process_id;
            index_reg <= slot_index;
            data_reg  <= EVENT_WIDTH'(event_data);
        end
    end

    // Decide the command against the selected slot
    always_comb
    begin
        wp_step      = 1'b0;
        rp_step      = 1'b0;
        lost_set     = 1'b0;
        lost_clr     = 1'b0;
        ring_clear   = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        res_status   = STATUS_OK;
        res_valid    = 1'b0;
        res_lost     = 1'b0;
        bind_req.en    = 1'b0;
        bind_req.slot  = bind_slot;
        bind_req.owner = pid_reg;
        ram_waddr    = store_addr(sel, wr_ptr_reg[sel]);
        ram_raddr    = store_addr(sel, rd_ptr_reg[sel]);
        if (state_reg == ST_LOOK)
        begin
            case (cmd_reg)
                CMD_ENQUEUE:
                begin
                    if (!match.hit)
                    begin
                        res_status = STATUS_MISSING;
                    end
                    else if (ptr_advance(wr_ptr_reg[sel]) == rd_ptr_reg[sel])
                    begin
                        lost_set   = 1'b1;
                        res_status = STATUS_FULL;
                    end
                    else
                    begin
                        ram_we  = 1'b1;
                        wp_step = 1'b1;
                    end
                end
                CMD_POLL:
                begin
                    if (!match.hit)
                    begin
                        res_status = STATUS_MISSING;
                    end
                    else if (lost_reg[sel])
                    begin
                        lost_clr = 1'b1;
                        res_lost = 1'b1;
                    end
                    else if (wr_ptr_reg[sel] != rd_ptr_reg[sel])
                    begin
                        ram_re    = 1'b1;
                        rp_step   = 1'b1;
                        res_valid = 1'b1;
                    end
                end
                CMD_BIND:
                begin
                    if (!bind_ok)
                    begin
                        res_status = STATUS_MISSING;
                    end
                    else
                    begin
                        bind_req.en = 1'b1;
                        ring_clear  = 1'b1;
                    end
                end
                default:
                begin
                    res_status = STATUS_OK;
                end
            endcase
        end
    end

    // Advance, drop or reset the ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
                lost_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            if (wp_step)
            begin
                wr_ptr_reg[sel] <= ptr_advance(wr_ptr_reg[sel]);
            end
            if (rp_step)
            begin
                rd_ptr_reg[sel] <= ptr_advance(rd_ptr_reg[sel]);
            end
            if (lost_set)
            begin
                lost_reg[sel] <= 1'b1;
            end
            if (lost_clr)
            begin
                lost_reg[sel] <= 1'b0;
            end
            if (ring_clear)
            begin
                wr_ptr_reg[bind_slot] <= '0;
                rd_ptr_reg[bind_slot] <= '0;
                lost_reg[bind_slot]   <= 1'b0;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        load_direct      = 1'b0;
        load_pend        = 1'b0;
        pend_status_next = pend_status_reg;
        pend_valid_next  = pend_valid_reg;
        pend_lost_next   = pend_lost_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                pend_status_next = res_status;
                pend_valid_next  = res_valid;
                pend_lost_next   = res_lost;
                if (!ram_re && out_free)
                begin
                    load_direct = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    load_pend  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_valid_reg  <= pend_valid_next;
        pend_lost_reg   <= pend_lost_next;
    end

    // Output register: load a result, drop it on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_direct || load_pend)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_direct)
        begin
            status_reg      <= res_status;
            event_valid_reg <= 1'b0;
            lost_report_reg <= res_lost;
            event_out_reg   <= '0;
        end
        else if (load_pend)
        begin
            status_reg      <= pend_status_reg;
            event_valid_reg <= pend_valid_reg;
            lost_report_reg <= pend_lost_reg;
            event_out_reg   <= pend_valid_reg ? DATA_W'(ram_rdata) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign event_valid = event_valid_reg;
    assign lost_report = lost_report_reg;
    assign event_out   = event_out_reg;

endmodule

// ===== tb/sv/tb_per_process_event_queues_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_process_event_queues_unit
// Self-checking bench for the per-process event queues unit.
// Commands go in over the input valid/ready channel. A behavioral copy of
// the slot table and rings predicts each response, and the responses coming
// out are compared field by field in order. Directed tests cover unbound
// owners, duplicate owners, rebinds, empty and full rings and the lost flag.
// Random traffic follows, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_per_process_event_queues_unit;

    import ppeq_pkg::*;

    // Command 3 has no meaning and must give an all-zero response
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int POOL_SIZE = 8;
    localparam int RANDOM_ITEMS = 1080;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                event_valid;
        logic                lost_report;
        logic [DATA_W-1:0]   event_out;
    } response_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     command;
    logic [PID_W-1:0]     process_id;
    logic [INDEX_W-1:0]   slot_index;
    logic [DATA_W-1:0]    event_data;
    logic                 out_valid;
    logic                 out_ready;
    logic [STATUS_W-1:0]  status;
    logic                 event_valid;
    logic                 lost_report;
    logic [DATA_W-1:0]    event_out;

    // Predicted slot table and rings
    logic                   owner_bound [SLOTS];
    logic [PID_W-1:0]       owner_pid   [SLOTS];
    logic                   drop_flag   [SLOTS];
    ptr_t                   head_ptr    [SLOTS];
    ptr_t                   tail_ptr    [SLOTS];
    logic [EVENT_WIDTH-1:0] ring_mem    [STORE_DEPTH];

    response_t        pending_responses[$];
    int               error_count;
    bit               in_burst;
    bit               out_burst;
    logic [PID_W-1:0] owner_pool [POOL_SIZE];

    per_process_event_queues_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .process_id  (process_id),
        .slot_index  (slot_index),
        .event_data  (event_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .event_valid (event_valid),
        .lost_report (lost_report),
        .event_out   (event_out)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Log one mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one command to the predicted state and return the response
    function automatic response_t run_queue_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [PID_W-1:0] pid,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic [DATA_W-1:0] data);
        response_t r;
        int        hit;
        int        i;
        ptr_t      fill;
        r = '0;
        r.status = STATUS_OK;
        hit = -1;
        // Lowest bound slot with a matching owner wins
        for (i = SLOTS - 1; i >= 0; i--)
        begin
            if (owner_bound[i] && owner_pid[i] == pid)
                hit = i;
        end
        case (cmd)
            CMD_ENQUEUE:
            begin
                if (hit < 0)
                    r.status = STATUS_MISSING;
                else
                begin
                    fill = head_ptr[hit] - tail_ptr[hit];
                    if (fill == ptr_t'(QUEUE_DEPTH - 1))
                    begin
                        drop_flag[hit] = 1'b1;
                        r.status = STATUS_FULL;
                    end
                    else
                    begin
                        ring_mem[hit * QUEUE_DEPTH + int'(head_ptr[hit])] =
                            data[EVENT_WIDTH-1:0];
                        head_ptr[hit] = head_ptr[hit] + ptr_t'(1);
                    end
                end
            end
            CMD_POLL:
            begin
                if (hit < 0)
                    r.status = STATUS_MISSING;
                else if (drop_flag[hit])
                begin
                    drop_flag[hit] = 1'b0;
                    r.lost_report = 1'b1;
                end
                else if (head_ptr[hit] != tail_ptr[hit])
                begin
                    r.event_out = DATA_W'(ring_mem[hit * QUEUE_DEPTH + int'(tail_ptr[hit])]);
                    r.event_valid = 1'b1;
                    tail_ptr[hit] = tail_ptr[hit] + ptr_t'(1);
                end
            end
            CMD_BIND:
            begin
                if (int'(idx) >= SLOTS)
                    r.status = STATUS_MISSING;
                else
                begin
                    owner_bound[idx] = 1'b1;
                    owner_pid[idx]   = pid;
                    drop_flag[idx]   = 1'b0;
                    head_ptr[idx]    = '0;
                    tail_ptr[idx]    = '0;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // Drive one command, hold it until the transfer, record the prediction
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic [PID_W-1:0] pid,
                                 input logic [INDEX_W-1:0] idx,
                                 input logic [DATA_W-1:0] data);
        int        gap;
        response_t predicted;
        gap = in_burst ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        process_id <= pid;
        slot_index <= idx;
        event_data <= data;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = run_queue_command(cmd, pid, idx, data);
        pending_responses = {pending_responses, predicted};
    endtask

    // Hold off the sender until every response is back
    task automatic drain_responses();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [INDEX_W-1:0] random_index();
        return INDEX_W'($urandom_range(0, 31));
    endfunction

    // Commands to owners that nobody has bound yet, and the empty command
    task automatic test_unbound_owners();
        issue_command(CMD_ENQUEUE, 16'h0000, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_command(CMD_POLL, 16'hFFFF, 5'd31, 64'h0);
        issue_command(CMD_NONE, 16'hFFFF, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_command(CMD_NONE, 16'h0000, 5'd0, 64'h0);
    endtask

    // Bind, duplicate owners, ordering, empty poll and rebind
    task automatic test_bind_and_dequeue();
        issue_command(CMD_BIND, 16'h0000, 5'd0, 64'h0);
        issue_command(CMD_BIND, 16'hFFFF, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_command(CMD_BIND, 16'hFFFF, 5'd5, 64'h0);
        issue_command(CMD_ENQUEUE, 16'hFFFF, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_command(CMD_ENQUEUE, 16'hFFFF, 5'd0, 64'h0);
        issue_command(CMD_ENQUEUE, 16'h0000, 5'd7, 64'h8000_0000_0000_0001);
        issue_command(CMD_POLL, 16'hFFFF, 5'd0, 64'h0);
        issue_command(CMD_POLL, 16'hFFFF, 5'd0, 64'h0);
        issue_command(CMD_POLL, 16'hFFFF, 5'd0, 64'h0);
        issue_command(CMD_POLL, 16'h0000, 5'd0, 64'h0);
        issue_command(CMD_POLL, 16'h0000, 5'd0, 64'h0);
        // Move slot 5 away so slot 31 serves the owner again
        issue_command(CMD_BIND, 16'h1234, 5'd5, 64'h0);
        issue_command(CMD_ENQUEUE, 16'hFFFF, 5'd0, 64'h5555_AAAA_5555_AAAA);
        issue_command(CMD_BIND, 16'hFFFF, 5'd31, 64'h0);
        issue_command(CMD_POLL, 16'hFFFF, 5'd0, 64'h0);
        issue_command(CMD_POLL, 16'hABCD, 5'd0, 64'h0);
    endtask

    // Fill one ring, overflow it, report the loss, and clear it by a rebind
    task automatic test_queue_full();
        issue_command(CMD_BIND, 16'h00A5, 5'd2, 64'h0);
        repeat (QUEUE_DEPTH + 1)
            issue_command(CMD_ENQUEUE, 16'h00A5, random_index(), random_word());
        issue_command(CMD_POLL, 16'h00A5, 5'd0, 64'h0);
        issue_command(CMD_POLL, 16'h00A5, 5'd0, 64'h0);
        issue_command(CMD_ENQUEUE, 16'h00A5, 5'd0, random_word());
        issue_command(CMD_ENQUEUE, 16'h00A5, 5'd0, random_word());
        issue_command(CMD_BIND, 16'h00A5, 5'd2, 64'h0);
        issue_command(CMD_POLL, 16'h00A5, 5'd0, 64'h0);
    endtask

    // Draw fresh owners and bind them to the low slots
    task automatic rebind_owner_pool();
        int i;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            owner_pool[i] = PID_W'($urandom_range(0, 65535));
            issue_command(CMD_BIND, owner_pool[i], INDEX_W'(i), random_word());
        end
    endtask

    // Mostly traffic to bound owners, with fill bursts, rebinds and noise
    task automatic test_random_traffic();
        int               sent;
        int               pick;
        int               n;
        logic [PID_W-1:0] pid;
        sent = 0;
        rebind_owner_pool();
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 15) == 0)
                in_burst = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 15) == 0)
                out_burst = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 299) == 0)
            begin
                rebind_owner_pool();
                sent += POOL_SIZE;
            end
            if ($urandom_range(0, 59) == 0)
                drain_responses();
            pid  = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                issue_command(CMD_BIND, pid,
                              ($urandom_range(0, 3) == 0) ? random_index()
                                                          : INDEX_W'($urandom_range(0, 7)),
                              random_word());
                sent++;
            end
            else if (pick < 20)
            begin
                n = $urandom_range(1, QUEUE_DEPTH + 4);
                repeat (n)
                    issue_command(CMD_ENQUEUE, pid, random_index(), random_word());
                sent += n;
            end
            else if (pick < 55)
            begin
                issue_command(CMD_ENQUEUE, pid, random_index(), random_word());
                sent++;
            end
            else if (pick < 88)
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 10) : 1;
                repeat (n)
                    issue_command(CMD_POLL, pid, random_index(), random_word());
                sent += n;
            end
            else if (pick < 95)
            begin
                issue_command(($urandom_range(0, 1) == 0) ? CMD_ENQUEUE : CMD_POLL,
                              PID_W'($urandom_range(0, 65535)), random_index(),
                              random_word());
                sent++;
            end
            else
            begin
                issue_command(CMD_NONE, PID_W'($urandom_range(0, 65535)), random_index(),
                              random_word());
                sent++;
            end
        end
    endtask

    // Stall the response side for a drawn number of cycles per transfer
    initial
    begin : response_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, 13);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Compare each response transfer with the oldest prediction
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_responses.size() == 0)
                report_mismatch("response with no command outstanding");
            else
            begin
                want = pending_responses.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.status));
                if (event_valid !== want.event_valid)
                    report_mismatch($sformatf("event_valid %0b, expected %0b",
                                              event_valid, want.event_valid));
                if (lost_report !== want.lost_report)
                    report_mismatch($sformatf("lost_report %0b, expected %0b",
                                              lost_report, want.lost_report));
                if (event_out !== want.event_out)
                    report_mismatch($sformatf("event_out %h, expected %h",
                                              event_out, want.event_out));
            end
        end
    end

    // Bound the run
    initial
    begin : watchdog
        #2_000_000;
        $display("per_process_event_queues_unit test failed");
        $finish;
    end

    initial
    begin : main_sequence
        int i;
        error_count = 0;
        in_burst    = 1'b0;
        out_burst   = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_NONE;
        process_id  = '0;
        slot_index  = '0;
        event_data  = '0;
        rst_n       = 1'b0;
        for (i = 0; i < SLOTS; i++)
        begin
            owner_bound[i] = 1'b0;
            owner_pid[i]   = '0;
            drop_flag[i]   = 1'b0;
            head_ptr[i]    = '0;
            tail_ptr[i]    = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unbound_owners();
        test_bind_and_dequeue();
        drain_responses();
        test_queue_full();
        drain_responses();
        test_random_traffic();

        // Let the last responses come back, then idle before the final check
        drain_responses();
        repeat (16) @(posedge clk);
        if (error_count == 0 && pending_responses.size() == 0)
            $display("per_process_event_queues_unit test passed");
        else
            $display("per_process_event_queues_unit test failed");
        $finish;
    end

endmodule
